### rtl/tone_access_relay_controller_core_assert.svh
// Assertion macros shared by the tone access relay controller RTL.
`ifndef TONE_ACCESS_RELAY_CONTROLLER_CORE_ASSERT_SVH
`define TONE_ACCESS_RELAY_CONTROLLER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define TARC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tarc: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define TARC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tarc: next-cycle check failed");
`else
`define TARC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TARC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/tarc_pkg.sv
// Package with types and constants of the tone access relay controller.
`timescale 1ns / 1ps
package tarc_pkg;

  localparam int CODE_DIGITS_DEF = 1;
  localparam int RELAY_COUNT_DEF = 6;

  localparam int TONE_W  = 4;
  localparam int RELAY_W = 6;
  localparam int HOLD_W  = 8;
  localparam int WIN_W   = 8;
  localparam int BLINK_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int RIDX_W  = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_RELAY_HOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_WINDOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PER   = 2'd2;

  localparam logic [HOLD_W-1:0]  RELAY_HOLD_RST = 8'd46;
  localparam logic [WIN_W-1:0]   CMD_WINDOW_RST = 8'd115;
  localparam logic [BLINK_W-1:0] BLINK_PER_RST  = 2'd3;
  localparam logic [BLINK_W-1:0] BLINK_CNT_RST  = 2'd3;

  // Decoder key codes.
  localparam logic [TONE_W-1:0] KEY_ONE  = 4'd1;
  localparam logic [TONE_W-1:0] KEY_ZERO = 4'd10;
  localparam logic [TONE_W-1:0] KEY_HASH = 4'd12;

  typedef enum logic [1:0] {
    PH_CODE = 2'd0,
    PH_CMD  = 2'd1,
    PH_PROG = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_DIGIT    = 4'd1,
    EV_ACCEPTED = 4'd2,
    EV_REJECTED = 4'd3,
    EV_RELAY    = 4'd4,
    EV_ALL_OFF  = 4'd5,
    EV_PROG     = 4'd6,
    EV_STORED   = 4'd7,
    EV_PROG_END = 4'd8,
    EV_EXPIRED  = 4'd9,
    EV_IGNORED  = 4'd10
  } event_e;

  // Commands from the sequencer to the relay bank.
  typedef struct packed {
    logic              walk;
    logic              toggle;
    logic              clear;
    logic [RIDX_W-1:0] idx;
  } relay_cmd_t;

endpackage

### rtl/tarc_in_if.sv
// Input channel carrying tone events and timer ticks.
`timescale 1ns / 1ps
interface tarc_in_if import tarc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [TONE_W-1:0] tone_code;

  modport source (output valid, mode, tone_code, input ready);
  modport sink (input valid, mode, tone_code, output ready);
endinterface

### rtl/tarc_out_if.sv
// Output channel carrying one status result per transfer.
`timescale 1ns / 1ps
interface tarc_out_if import tarc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RELAY_W-1:0] relays;
  logic               led;
  logic [1:0]         phase;
  logic [3:0]         event_res;

  modport source (output valid, relays, led, phase, event_res, input ready);
  modport sink (input valid, relays, led, phase, event_res, output ready);
endinterface

### rtl/tarc_relay_bank.sv
// Relay drive bits and auto-release countdowns with one shared decrementer.
`timescale 1ns / 1ps
module tarc_relay_bank import tarc_pkg::*; #(
  parameter int RELAY_COUNT = RELAY_COUNT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  relay_cmd_t             cmd_i,
  input  logic [HOLD_W-1:0]      hold_i,
  output logic [RELAY_COUNT-1:0] relays_o,
  output logic                   busy_o
);

  localparam int RI_W = (RELAY_COUNT > 1) ? $clog2(RELAY_COUNT) : 1;
  localparam logic [RI_W-1:0] RI_LAST = RI_W'(RELAY_COUNT - 1);

  logic [HOLD_W-1:0]      cd_q [RELAY_COUNT];
  logic [RELAY_COUNT-1:0] bits_q, bits_d;
  logic [RI_W-1:0]        walk_idx_q;
  logic                   busy_q;

  logic [HOLD_W-1:0] cur_cd;
  logic              cd_we;
  logic [RI_W-1:0]   cd_widx;
  logic [HOLD_W-1:0] cd_wdata;
  logic [RI_W-1:0]   cmd_idx;

  assign cmd_idx = cmd_i.idx[RI_W-1:0];
  assign cur_cd  = cd_q[walk_idx_q];

  // During a walk the shared decrementer visits one countdown per cycle.
  always_comb begin
    bits_d   = bits_q;
    cd_we    = 1'b0;
    cd_widx  = walk_idx_q;
    cd_wdata = cur_cd - HOLD_W'(1);
    if (busy_q) begin
      if (cur_cd != '0) begin
        cd_we = 1'b1;
        if (cur_cd == HOLD_W'(1)) begin
          bits_d[walk_idx_q] = 1'b0;
        end
      end
    end else if (cmd_i.toggle) begin
      bits_d[cmd_idx] = ~bits_q[cmd_idx];
      cd_we    = 1'b1;
      cd_widx  = cmd_idx;
      cd_wdata = hold_i;
    end else if (cmd_i.clear) begin
      bits_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RELAY_COUNT; i++) begin
        cd_q[i] <= '0;
      end
      bits_q     <= '0;
      walk_idx_q <= '0;
      busy_q     <= 1'b0;
    end else begin
      bits_q <= bits_d;
      if (cd_we) begin
        cd_q[cd_widx] <= cd_wdata;
      end
      if (busy_q) begin
        if (walk_idx_q == RI_LAST) begin
          busy_q <= 1'b0;
        end else begin
          walk_idx_q <= walk_idx_q + RI_W'(1);
        end
      end else if (cmd_i.walk) begin
        busy_q     <= 1'b1;
        walk_idx_q <= '0;
      end
    end
  end

  assign relays_o = bits_q;
  assign busy_o   = busy_q;

endmodule

### rtl/tone_access_relay_controller_core.sv
// Top level of the tone access relay controller.
`timescale 1ns / 1ps
// The controller takes one item at a time on in_i: either a keypad tone
// (mode 0, decoder nibble in tone_code) or one timer tick (mode 1), and
// returns exactly one status transfer on out_o with the relay bits, the LED,
// the session phase and an event code. A caller enters the access code, then
// one command key in the command window: keys 1 to RELAY_COUNT toggle a relay
// and arm its auto-release countdown, key 0 releases all relays, and hash
// enters programming, where the next CODE_DIGITS keys become the new code
// while the LED blinks. A plain tone is decided in its transfer cycle and
// then posted. The last code digit is checked by the digit comparator,
// which checks one stored digit per cycle. A tick waits for the relay bank,
// which walks its countdowns through a single shared decrementer, one relay
// per cycle, and the sequencer sees the walk finish in the cycle after the
// last relay. The input is not ready while an item is being worked on; a
// finished result sits in the output register, so the next item is taken
// even if out_o is stalled. Configuration writes on cfg_we_i take effect at
// the next clock edge and must be issued while idle.
`include "tone_access_relay_controller_core_assert.svh"
module tone_access_relay_controller_core import tarc_pkg::*; #(
  parameter int CODE_DIGITS = CODE_DIGITS_DEF,
  parameter int RELAY_COUNT = RELAY_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tarc_in_if.sink               in_i,
  tarc_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int DP_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam logic [DP_W-1:0] DP_LAST = DP_W'(CODE_DIGITS - 1);
  localparam logic [DP_W:0]   DP_LIMIT = (DP_W + 1)'(CODE_DIGITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_WALK,
    S_DONE
  } state_e;

  // Configuration registers.
  logic [HOLD_W-1:0]  hold_q;
  logic [WIN_W-1:0]   win_q;
  logic [BLINK_W-1:0] blink_per_q;

  // Session state.
  state_e              state_q, state_d;
  phase_e              phase_q, phase_d;
  logic [DP_W-1:0]     dp_q, dp_d;
  logic                led_q, led_d;
  logic [WIN_W-1:0]    wc_q, wc_d;
  logic [BLINK_W-1:0]  blink_cnt_q, blink_cnt_d;
  logic                blink_ph_q, blink_ph_d;
  event_e              ev_q, ev_d;
  logic [DP_W-1:0]     cmp_idx_q, cmp_idx_d;
  logic                mismatch_q, mismatch_d;
  logic [TONE_W-1:0]   stored_q [CODE_DIGITS];
  logic [TONE_W-1:0]   entered_q [CODE_DIGITS];
  logic                out_valid_q, out_valid_d;

  // Output payload register.
  logic [RELAY_W-1:0]  out_relays_q;
  logic                out_led_q;
  logic [1:0]          out_phase_q;
  logic [3:0]          out_ev_q;

  logic                accept;
  logic                out_load;
  logic [TONE_W-1:0]   key;
  logic                key_valid;
  logic [DP_W-1:0]     dp_eff;
  logic                last_digit;
  logic                entered_we;
  logic                stored_we;
  logic [WIN_W-1:0]    wc_dec;
  logic [TONE_W-1:0]   stored_norm;
  logic                digit_ne;
  relay_cmd_t          bank_cmd;
  logic [RELAY_COUNT-1:0] bank_relays;
  logic                bank_busy;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign key        = in_i.tone_code;
  assign key_valid  = (key >= KEY_ONE) && (key <= KEY_HASH);

  // A position past the code length restarts at the first digit.
  assign dp_eff     = ({1'b0, dp_q} >= DP_LIMIT) ? '0 : dp_q;
  assign last_digit = (dp_eff == DP_LAST);
  assign wc_dec     = (wc_q != '0) ? (wc_q - WIN_W'(1)) : wc_q;

  // The shared digit comparator: a stored star or hash counts as key zero.
  assign stored_norm = (stored_q[cmp_idx_q] > KEY_ZERO) ? KEY_ZERO : stored_q[cmp_idx_q];
  assign digit_ne    = (entered_q[cmp_idx_q] != stored_norm);

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  tarc_relay_bank #(
    .RELAY_COUNT(RELAY_COUNT)
  ) u_relay_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (bank_cmd),
    .hold_i  (hold_q),
    .relays_o(bank_relays),
    .busy_o  (bank_busy)
  );

  // Sequencer: the transfer cycle decides everything that needs no walk;
  // code checks and ticks then run their walk before the result is posted.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    dp_d        = dp_q;
    led_d       = led_q;
    wc_d        = wc_q;
    blink_cnt_d = blink_cnt_q;
    blink_ph_d  = blink_ph_q;
    ev_d        = ev_q;
    cmp_idx_d   = cmp_idx_q;
    mismatch_d  = mismatch_q;
    entered_we  = 1'b0;
    stored_we   = 1'b0;
    bank_cmd    = '0;
    out_valid_d = out_valid_q;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.mode) begin
            ev_d = EV_NONE;
            if (phase_q == PH_PROG) begin
              if (blink_cnt_q <= BLINK_W'(1)) begin
                led_d       = blink_ph_q;
                blink_ph_d  = ~blink_ph_q;
                blink_cnt_d = blink_per_q;
              end else begin
                blink_cnt_d = blink_cnt_q - BLINK_W'(1);
              end
            end
            if ((phase_q == PH_CMD) || (phase_q == PH_PROG)) begin
              wc_d = wc_dec;
              if (wc_dec == '0) begin
                phase_d = PH_CODE;
                led_d   = 1'b0;
                dp_d    = '0;
                ev_d    = EV_EXPIRED;
              end
            end
            bank_cmd.walk = 1'b1;
            state_d       = S_WALK;
          end else begin
            state_d = S_DONE;
            if (!key_valid) begin
              ev_d = EV_IGNORED;
            end else begin
              case (phase_q)
                PH_CODE: begin
                  entered_we = 1'b1;
                  if (!last_digit) begin
                    dp_d = dp_eff + DP_W'(1);
                    ev_d = EV_DIGIT;
                  end else begin
                    dp_d       = '0;
                    cmp_idx_d  = '0;
                    mismatch_d = 1'b0;
                    state_d    = S_CMP;
                  end
                end
                PH_CMD: begin
                  if (wc_q == '0) begin
                    phase_d = PH_CODE;
                    led_d   = 1'b0;
                    dp_d    = '0;
                    ev_d    = EV_EXPIRED;
                  end else if (key == KEY_HASH) begin
                    phase_d = PH_PROG;
                    dp_d    = '0;
                    ev_d    = EV_PROG;
                  end else begin
                    phase_d = PH_CODE;
                    led_d   = 1'b0;
                    dp_d    = '0;
                    if (key == KEY_ZERO) begin
                      bank_cmd.clear = 1'b1;
                      ev_d           = EV_ALL_OFF;
                    end else if (key <= TONE_W'(RELAY_COUNT)) begin
                      bank_cmd.toggle = 1'b1;
                      bank_cmd.idx    = RIDX_W'(key - KEY_ONE);
                      ev_d            = EV_RELAY;
                    end else begin
                      ev_d = EV_IGNORED;
                    end
                  end
                end
                PH_PROG: begin
                  if (wc_q == '0) begin
                    phase_d = PH_CODE;
                    led_d   = 1'b0;
                    dp_d    = '0;
                    ev_d    = EV_EXPIRED;
                  end else begin
                    stored_we = 1'b1;
                    if (!last_digit) begin
                      dp_d = dp_eff + DP_W'(1);
                      ev_d = EV_STORED;
                    end else begin
                      phase_d = PH_CODE;
                      led_d   = 1'b0;
                      dp_d    = '0;
                      ev_d    = EV_PROG_END;
                    end
                  end
                end
                default: begin
                  phase_d = PH_CODE;
                  led_d   = 1'b0;
                  dp_d    = '0;
                  ev_d    = EV_IGNORED;
                end
              endcase
            end
          end
        end
      end
      S_CMP: begin
        mismatch_d = mismatch_q | digit_ne;
        if (cmp_idx_q == DP_LAST) begin
          state_d = S_DONE;
          if (!(mismatch_q || digit_ne)) begin
            phase_d = PH_CMD;
            led_d   = 1'b1;
            wc_d    = win_q;
            ev_d    = EV_ACCEPTED;
          end else begin
            ev_d = EV_REJECTED;
          end
        end else begin
          cmp_idx_d = cmp_idx_q + DP_W'(1);
        end
      end
      S_WALK: begin
        if (!bank_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= RELAY_HOLD_RST;
      win_q       <= CMD_WINDOW_RST;
      blink_per_q <= BLINK_PER_RST;
      state_q     <= S_IDLE;
      phase_q     <= PH_CODE;
      dp_q        <= '0;
      led_q       <= 1'b0;
      wc_q        <= '0;
      blink_cnt_q <= BLINK_CNT_RST;
      blink_ph_q  <= 1'b0;
      ev_q        <= EV_NONE;
      cmp_idx_q   <= '0;
      mismatch_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        stored_q[i] <= KEY_ZERO;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RELAY_HOLD: hold_q      <= cfg_data_i[HOLD_W-1:0];
          REG_CMD_WINDOW: win_q       <= cfg_data_i[WIN_W-1:0];
          REG_BLINK_PER:  blink_per_q <= cfg_data_i[BLINK_W-1:0];
          default: begin
          end
        endcase
      end
      state_q     <= state_d;
      phase_q     <= phase_d;
      dp_q        <= dp_d;
      led_q       <= led_d;
      wc_q        <= wc_d;
      blink_cnt_q <= blink_cnt_d;
      blink_ph_q  <= blink_ph_d;
      ev_q        <= ev_d;
      cmp_idx_q   <= cmp_idx_d;
      mismatch_q  <= mismatch_d;
      out_valid_q <= out_valid_d;
      if (stored_we) begin
        stored_q[dp_eff] <= key;
      end
    end
  end

  // Entered digits and the output payload carry no reset.
  always_ff @(posedge clk_i) begin
    if (entered_we) begin
      entered_q[dp_eff] <= key;
    end
    if (out_load) begin
      out_relays_q <= RELAY_W'(bank_relays);
      out_led_q    <= led_q;
      out_phase_q  <= phase_q;
      out_ev_q     <= ev_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.relays    = out_relays_q;
  assign out_o.led       = out_led_q;
  assign out_o.phase     = out_phase_q;
  assign out_o.event_res = out_ev_q;

  // A transfer always starts work, so the input drops ready in the next cycle.
  `TARC_ASSERT_NXT(a_accept_starts_work, clk_i, rst_ni, accept, state_q != S_IDLE)
  // The relay bank walks only while the sequencer waits for it.
  `TARC_ASSERT_IMP(a_walk_owned, clk_i, rst_ni, bank_busy, state_q == S_WALK)
  // An open command window always shows the LED lit.
  `TARC_ASSERT_IMP(a_cmd_led_on, clk_i, rst_ni, (state_q == S_IDLE) && (phase_q == PH_CMD), led_q)

endmodule
